/* rtl/ptp_pkg.sv */
package ptp_pkg;

  localparam int MaxBandsDefault = 8;
  localparam logic [31:0] LockTimeoutReset = 32'd1000;
  localparam logic [31:0] PollStepMs = 32'd50;
  localparam logic [7:0] AuxCtrlMask = 8'h18;
  localparam logic [7:0] StopCtrlMask = 8'h01;
  localparam int LockBit = 6;

  localparam logic [2:0] OpLoad  = 3'd0;
  localparam logic [2:0] OpTune  = 3'd1;
  localparam logic [2:0] OpStart = 3'd2;
  localparam logic [2:0] OpPoll  = 3'd3;
  localparam logic [2:0] OpStop  = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StRange   = 3'd1;
  localparam logic [2:0] StNoConf  = 3'd2;
  localparam logic [2:0] StWait    = 3'd3;
  localparam logic [2:0] StTimeout = 3'd4;
  localparam logic [2:0] StIgnored = 3'd5;

  localparam logic [1:0] CfgIf      = 2'd0;
  localparam logic [1:0] CfgBands   = 2'd1;
  localparam logic [1:0] CfgTimeout = 2'd2;
  localparam logic [1:0] CfgAuxSkip = 2'd3;

  typedef enum logic [1:0] {
    ModeUnconf = 2'd0,
    ModeConf   = 2'd1,
    ModeLocked = 2'd2
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_band;
    logic search_init;
    logic search_step;
    logic div_init;
    logic div_step;
    logic store_cmd;
    logic clear_elapsed;
    logic add_elapsed;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic index_ok;
    logic search_hit;
    logic search_done;
    logic div_done;
    logic aux_skip;
    logic timeout_hit;
  } dp_status_t;

endpackage

/* rtl/pll_tuner_programmer_top.sv */
// Load band, poll and other single reports give their result in the cycle after acceptance,
// and such commands can be accepted on every cycle.
// Tune examines the bands in table order and reports out of range when none fits; on a hit it
// divides IF plus tuning frequency by the band step bit-serially, stores the command and reports.
// Start emits up to 7 results and stop 3, one per cycle; busy drops in the final result cycle.
// Synchronous reset clears mode, lock wait, elapsed time and registers, not the band table.
module pll_tuner_programmer_top
  import ptp_pkg::*;
#(
  parameter int MAX_BANDS = MaxBandsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  op,
  input  logic [2:0]  band_index,
  input  logic [31:0] band_min_hz,
  input  logic [31:0] band_max_hz,
  input  logic [31:0] band_step_hz,
  input  logic [7:0]  band_control,
  input  logic [7:0]  band_switch,
  input  logic [7:0]  band_aux,
  input  logic [31:0] tune_frequency_hz,
  input  logic [7:0]  status_value,
  output logic        strobe,
  output logic        kind,
  output logic [7:0]  bus_byte,
  output logic        frame_end,
  output logic [2:0]  status_code,
  output logic        last
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [7:0] cmd_byte [5];

  ptp_datapath #(.MAX_BANDS(MAX_BANDS)) u_datapath (
    .clk, .rst,
    .cfg_write(cfg_we), .cfg_index, .cfg_data,
    .band_index, .band_min_hz, .band_max_hz, .band_step_hz,
    .band_control, .band_switch, .band_aux, .tune_frequency_hz,
    .cmd, .status, .cmd_byte
  );

  ptp_controller u_controller (
    .clk, .rst, .start, .op,
    .status_value, .status, .cmd_byte,
    .busy, .cmd, .strobe, .kind, .bus_byte, .frame_end, .status_code, .last
  );

endmodule

/* rtl/ptp_datapath.sv */
module ptp_datapath
  import ptp_pkg::*;
#(
  parameter int MAX_BANDS = MaxBandsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [2:0]        band_index,
  input  logic [31:0]       band_min_hz,
  input  logic [31:0]       band_max_hz,
  input  logic [31:0]       band_step_hz,
  input  logic [7:0]        band_control,
  input  logic [7:0]        band_switch,
  input  logic [7:0]        band_aux,
  input  logic [31:0]       tune_frequency_hz,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic [7:0]        cmd_byte [5]
);

  localparam int IdxW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int CntW = $clog2(MAX_BANDS + 1);

  logic [31:0] if_freq;
  logic [3:0]  bands_in_use;
  logic [31:0] lock_timeout;
  logic [7:0]  aux_skip;

  logic [31:0] low_mem  [MAX_BANDS];
  logic [31:0] high_mem [MAX_BANDS];
  logic [31:0] step_mem [MAX_BANDS];
  logic [23:0] byte_mem [MAX_BANDS];

  logic [IdxW-1:0] wr_idx;
  logic        index_ok;
  logic [CntW-1:0] search_idx;
  logic [CntW-1:0] search_count;
  logic [31:0] freq;
  logic [31:0] rd_low, rd_high, rd_step;
  logic [23:0] rd_bytes;
  logic        rd_valid;
  logic [31:0] hit_step;
  logic [23:0] hit_bytes;

  logic [31:0] quot;
  logic [31:0] rem;
  logic [5:0]  div_count;
  logic [31:0] elapsed;
  logic [32:0] trial;
  logic [32:0] elapsed_sum;

  assign wr_idx = IdxW'(band_index);
  assign index_ok = ({29'd0, band_index} < MAX_BANDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      if_freq <= '0;
      bands_in_use <= '0;
      lock_timeout <= LockTimeoutReset;
      aux_skip <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgIf:      if_freq <= cfg_data;
        CfgBands:   bands_in_use <= cfg_data[3:0];
        CfgTimeout: lock_timeout <= cfg_data;
        CfgAuxSkip: aux_skip <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_band && index_ok) begin
      low_mem[wr_idx]  <= band_min_hz;
      high_mem[wr_idx] <= band_max_hz;
      step_mem[wr_idx] <= band_step_hz;
      byte_mem[wr_idx] <= {band_aux, band_switch, band_control};
    end
  end

  always_ff @(posedge clk) begin
    rd_low   <= low_mem[search_idx[IdxW-1:0]];
    rd_high  <= high_mem[search_idx[IdxW-1:0]];
    rd_step  <= step_mem[search_idx[IdxW-1:0]];
    rd_bytes <= byte_mem[search_idx[IdxW-1:0]];
  end

  assign trial = {rem[31:0], quot[31]} - {1'b0, hit_step};
  assign elapsed_sum = {1'b0, elapsed} + {1'b0, PollStepMs};

  always_ff @(posedge clk) begin
    if (rst) begin
      search_idx <= '0;
      rd_valid <= 1'b0;
      elapsed <= '0;
      div_count <= '0;
    end else begin
      if (cmd.search_init) begin
        search_idx <= '0;
        rd_valid <= 1'b0;
        freq <= tune_frequency_hz;
        if ({28'd0, bands_in_use} > MAX_BANDS) begin
          search_count <= CntW'(MAX_BANDS);
        end else begin
          search_count <= CntW'(bands_in_use);
        end
      end else if (cmd.search_step) begin
        if (!rd_valid) begin
          rd_valid <= 1'b1;
        end else begin
          search_idx <= search_idx + 1'b1;
          rd_valid <= 1'b0;
          hit_step <= rd_step;
          hit_bytes <= rd_bytes;
        end
      end
      if (cmd.div_init) begin
        quot <= if_freq + freq;
        rem <= '0;
        div_count <= '0;
      end else if (cmd.div_step) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quot[31]};
          quot <= {quot[30:0], 1'b0};
        end
        div_count <= div_count + 1'b1;
      end
      if (cmd.clear_elapsed) begin
        elapsed <= '0;
      end else if (cmd.add_elapsed) begin
        elapsed <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_cmd) begin
      if (hit_step == '0) begin
        cmd_byte[0] <= 8'hFF;
        cmd_byte[1] <= 8'hFF;
      end else begin
        cmd_byte[0] <= quot[15:8];
        cmd_byte[1] <= quot[7:0];
      end
      cmd_byte[2] <= hit_bytes[7:0];
      cmd_byte[3] <= hit_bytes[15:8];
      cmd_byte[4] <= hit_bytes[23:16];
    end
  end

  logic [31:0] elapsed_new;
  assign elapsed_new = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];

  assign status.index_ok    = index_ok;
  assign status.search_hit  = rd_valid && (rd_low <= freq) && (rd_high >= freq);
  assign status.search_done = rd_valid ? 1'b0 : (search_idx >= search_count);
  assign status.div_done    = (div_count == 6'd32);
  assign status.aux_skip    = (cmd_byte[4] == aux_skip);
  assign status.timeout_hit = (elapsed_new >= lock_timeout);

endmodule

/* rtl/ptp_controller.sv */
module ptp_controller
  import ptp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  op,
  input  logic [7:0]  status_value,
  input  dp_status_t  status,
  input  logic [7:0]  cmd_byte [5],
  output logic        busy,
  output dp_cmd_t     cmd,
  output logic        strobe,
  output logic        kind,
  output logic [7:0]  bus_byte,
  output logic        frame_end,
  output logic [2:0]  status_code,
  output logic        last
);

  typedef enum logic [2:0] {
    SIdle, SSearch, SDivide, SStore, SEmit
  } state_t;

  state_t state;
  mode_t  mode;
  logic   waiting;
  logic [2:0] seq_pos;
  logic [2:0] seq_len;
  logic [2:0] final_code;
  logic       from_start;

  assign busy = (state != SIdle);

  always_comb begin
    cmd = '0;
    cmd.load_band     = (state == SIdle) && start && (op == OpLoad);
    cmd.search_init   = (state == SIdle) && start && (op == OpTune);
    cmd.search_step   = (state == SSearch) && !status.search_hit && !status.search_done;
    cmd.div_init      = (state == SSearch) && status.search_hit;
    cmd.div_step      = (state == SDivide) && !status.div_done;
    cmd.store_cmd     = (state == SStore);
    cmd.clear_elapsed = (state == SIdle) && start && (op == OpStart) && (mode == ModeConf);
    cmd.add_elapsed   = (state == SIdle) && start && (op == OpPoll) && waiting &&
                        !status_value[LockBit];
    if (status.search_hit) cmd.search_step = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      mode <= ModeUnconf;
      waiting <= 1'b0;
      strobe <= 1'b0;
      kind <= 1'b0;
      bus_byte <= '0;
      frame_end <= 1'b0;
      status_code <= '0;
      last <= 1'b0;
      seq_pos <= '0;
      seq_len <= '0;
      final_code <= '0;
      from_start <= 1'b0;
    end else begin
      strobe <= 1'b0;
      kind <= 1'b1;
      bus_byte <= '0;
      frame_end <= 1'b0;
      status_code <= '0;
      last <= 1'b0;
      case (state)
        SIdle: begin
          if (start) begin
            case (op)
              OpLoad: begin
                strobe <= 1'b1;
                last <= 1'b1;
                status_code <= status.index_ok ? StOk : StIgnored;
              end
              OpTune: state <= SSearch;
              OpStart: begin
                if (mode == ModeUnconf || mode == ModeLocked) begin
                  strobe <= 1'b1;
                  last <= 1'b1;
                  status_code <= (mode == ModeUnconf) ? StNoConf : StOk;
                end else begin
                  waiting <= 1'b1;
                  from_start <= 1'b1;
                  seq_pos <= status.aux_skip ? 3'd2 : 3'd0;
                  seq_len <= 3'd6;
                  final_code <= StWait;
                  state <= SEmit;
                end
              end
              OpPoll: begin
                strobe <= 1'b1;
                last <= 1'b1;
                if (!waiting) begin
                  status_code <= StIgnored;
                end else if (status_value[LockBit]) begin
                  mode <= ModeLocked;
                  waiting <= 1'b0;
                  status_code <= StOk;
                end else if (status.timeout_hit) begin
                  waiting <= 1'b0;
                  status_code <= StTimeout;
                end else begin
                  status_code <= StWait;
                end
              end
              OpStop: begin
                if (mode == ModeUnconf) begin
                  strobe <= 1'b1;
                  last <= 1'b1;
                  status_code <= StIgnored;
                end else begin
                  mode <= ModeUnconf;
                  waiting <= 1'b0;
                  from_start <= 1'b0;
                  seq_pos <= '0;
                  seq_len <= 3'd2;
                  final_code <= StOk;
                  state <= SEmit;
                end
              end
              default: begin
                strobe <= 1'b1;
                last <= 1'b1;
                status_code <= StIgnored;
              end
            endcase
          end
        end
        SSearch: begin
          if (status.search_hit) begin
            state <= SDivide;
          end else if (status.search_done) begin
            strobe <= 1'b1;
            last <= 1'b1;
            status_code <= StRange;
            state <= SIdle;
          end
        end
        SDivide: begin
          if (status.div_done) state <= SStore;
        end
        SStore: begin
          mode <= ModeConf;
          waiting <= 1'b0;
          strobe <= 1'b1;
          last <= 1'b1;
          status_code <= StOk;
          state <= SIdle;
        end
        SEmit: begin
          strobe <= 1'b1;
          if (seq_pos == seq_len) begin
            last <= 1'b1;
            status_code <= final_code;
            state <= SIdle;
          end else begin
            kind <= 1'b0;
            seq_pos <= seq_pos + 1'b1;
            if (from_start) begin
              case (seq_pos)
                3'd0: bus_byte <= cmd_byte[2] | AuxCtrlMask;
                3'd1: begin bus_byte <= cmd_byte[4]; frame_end <= 1'b1; end
                3'd2: bus_byte <= cmd_byte[0];
                3'd3: bus_byte <= cmd_byte[1];
                3'd4: bus_byte <= cmd_byte[2];
                default: begin bus_byte <= cmd_byte[3]; frame_end <= 1'b1; end
              endcase
            end else begin
              if (seq_pos == 3'd0) begin
                bus_byte <= cmd_byte[2] | StopCtrlMask;
              end else begin
                bus_byte <= cmd_byte[3];
                frame_end <= 1'b1;
              end
            end
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

/* tb/sv/pll_tuner_programmer_top_tb.sv */
`timescale 1ns / 100ps

module pll_tuner_programmer_top_tb;
  import ptp_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] bus_byte;
    logic       frame_end;
    logic [2:0] status_code;
    logic       last;
  } pll_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CfgIf;
  logic [31:0] cfg_data = '0;
  logic [2:0]  op = OpLoad;
  logic [2:0]  band_index = '0;
  logic [31:0] band_min_hz = '0;
  logic [31:0] band_max_hz = '0;
  logic [31:0] band_step_hz = '0;
  logic [7:0]  band_control = '0;
  logic [7:0]  band_switch = '0;
  logic [7:0]  band_aux = '0;
  logic [31:0] tune_frequency_hz = '0;
  logic [7:0]  status_value = '0;
  logic        strobe;
  logic        kind;
  logic [7:0]  bus_byte;
  logic        frame_end;
  logic [2:0]  status_code;
  logic        last;

  pll_tuner_programmer_top i_dut (.*);

  always #4 clk = ~clk;

  // Predicted state of the programmer.
  logic [31:0] if_hz;
  logic [3:0]  bands_used;
  logic [31:0] lock_limit_ms;
  logic [7:0]  aux_skip;
  mode_t       mode;
  logic        lock_wait;
  logic [31:0] elapsed;
  logic [31:0] low_tab [8];
  logic [31:0] high_tab [8];
  logic [31:0] step_tab [8];
  logic [23:0] byte_tab [8];
  logic [7:0]  cmd_bytes [5];

  pll_result_t expected_results [$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;

  task automatic push_byte(input logic [7:0] b, input logic fe);
    expected_results.push_back('{1'b0, b, fe, StOk, 1'b0});
  endtask

  task automatic push_status(input logic [2:0] code);
    expected_results.push_back('{1'b1, 8'h00, 1'b0, code, 1'b1});
  endtask

  task automatic predict_command();
    int          count;
    logic [31:0] sum;
    logic [31:0] divider;
    logic        hit;
    hit = 1'b0;
    case (op)
      OpLoad: begin
        low_tab[band_index] = band_min_hz;
        high_tab[band_index] = band_max_hz;
        step_tab[band_index] = band_step_hz;
        byte_tab[band_index] = {band_aux, band_switch, band_control};
        push_status(StOk);
      end
      OpTune: begin
        count = (bands_used > 8) ? 8 : bands_used;
        for (int i = 0; i < count && !hit; i++) begin
          if (low_tab[i] <= tune_frequency_hz && high_tab[i] >= tune_frequency_hz) begin
            hit = 1'b1;
            sum = if_hz + tune_frequency_hz;
            divider = (step_tab[i] == 0) ? 32'hFFFF_FFFF : sum / step_tab[i];
            cmd_bytes[0] = divider[15:8];
            cmd_bytes[1] = divider[7:0];
            cmd_bytes[2] = byte_tab[i][7:0];
            cmd_bytes[3] = byte_tab[i][15:8];
            cmd_bytes[4] = byte_tab[i][23:16];
            mode = ModeConf;
            lock_wait = 1'b0;
          end
        end
        push_status(hit ? StOk : StRange);
      end
      OpStart: begin
        if (mode == ModeUnconf) begin
          push_status(StNoConf);
        end else if (mode == ModeLocked) begin
          push_status(StOk);
        end else begin
          if (cmd_bytes[4] != aux_skip) begin
            push_byte(cmd_bytes[2] | AuxCtrlMask, 1'b0);
            push_byte(cmd_bytes[4], 1'b1);
          end
          push_byte(cmd_bytes[0], 1'b0);
          push_byte(cmd_bytes[1], 1'b0);
          push_byte(cmd_bytes[2], 1'b0);
          push_byte(cmd_bytes[3], 1'b1);
          elapsed = '0;
          lock_wait = 1'b1;
          push_status(StWait);
        end
      end
      OpPoll: begin
        if (!lock_wait) begin
          push_status(StIgnored);
        end else if (status_value[LockBit]) begin
          mode = ModeLocked;
          lock_wait = 1'b0;
          push_status(StOk);
        end else begin
          elapsed = (elapsed > 32'hFFFF_FFFF - PollStepMs) ? 32'hFFFF_FFFF
                                                           : elapsed + PollStepMs;
          if (elapsed >= lock_limit_ms) begin
            lock_wait = 1'b0;
            push_status(StTimeout);
          end else begin
            push_status(StWait);
          end
        end
      end
      OpStop: begin
        if (mode == ModeUnconf) begin
          push_status(StIgnored);
        end else begin
          push_byte(cmd_bytes[2] | StopCtrlMask, 1'b0);
          push_byte(cmd_bytes[3], 1'b1);
          mode = ModeUnconf;
          lock_wait = 1'b0;
          push_status(StOk);
        end
      end
      default: push_status(StIgnored);
    endcase
  endtask

  // All band, tuning and status inputs are randomised; callers then set the ones that matter.
  task automatic scramble_fields();
    band_index = 3'($urandom);
    band_min_hz = $urandom;
    band_max_hz = $urandom;
    band_step_hz = $urandom;
    band_control = 8'($urandom);
    band_switch = 8'($urandom);
    band_aux = 8'($urandom);
    tune_frequency_hz = $urandom;
    status_value = 8'($urandom);
  endtask

  // Entered and left at a falling edge.
  task automatic send_command(input logic [2:0] code);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    op = code;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_command();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CfgIf:      if_hz = value;
      CfgBands:   bands_used = value[3:0];
      CfgTimeout: lock_limit_ms = value;
      default:    aux_skip = value[7:0];
    endcase
  endtask

  task automatic load_band(input logic [2:0] idx, input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] step, input logic [7:0] ctl,
                           input logic [7:0] sw, input logic [7:0] aux);
    scramble_fields();
    band_index = idx;
    band_min_hz = lo;
    band_max_hz = hi;
    band_step_hz = step;
    band_control = ctl;
    band_switch = sw;
    band_aux = aux;
    send_command(OpLoad);
  endtask

  task automatic tune(input logic [31:0] freq);
    scramble_fields();
    tune_frequency_hz = freq;
    send_command(OpTune);
  endtask

  task automatic poll(input logic locked);
    scramble_fields();
    status_value[LockBit] = locked;
    send_command(OpPoll);
  endtask

  task automatic test_idle_commands();
    scramble_fields();
    tune(32'h1234_5678);
    send_command(OpStart);
    poll(1'b1);
    send_command(OpStop);
    scramble_fields();
    send_command(3'd5);
    send_command(3'd7);
  endtask

  task automatic test_band_table();
    load_band(3'd0, 32'd0, 32'd1000, 32'd0, 8'h00, 8'hFF, 8'h00);
    load_band(3'd1, 32'd500, 32'hFFFF_FFFF, 32'd1, 8'hFF, 8'h00, 8'hFF);
    for (int i = 2; i < 8; i++)
      load_band(i[2:0], $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
                8'($urandom));
    write_register(CfgBands, 32'd8);
  endtask

  task automatic test_lock_sequence();
    tune(32'd700);
    send_command(OpStart);
    poll(1'b0);
    poll(1'b1);
    send_command(OpStart);
    send_command(OpStop);
    write_register(CfgIf, 32'hFFFF_FFFF);
    write_register(CfgAuxSkip, 32'hFF);
    tune(32'hFFFF_FFFF);
    send_command(OpStart);
    send_command(OpStart);
    send_command(OpStop);
    write_register(CfgTimeout, 32'd0);
    tune(32'd20);
    send_command(OpStart);
    poll(1'b0);
    poll(1'b0);
    write_register(CfgBands, 32'd15);
    tune(32'd400);
    write_register(CfgBands, 32'd1);
    tune(32'd2000);
  endtask

  task automatic random_band();
    logic [31:0] lo, hi;
    lo = $urandom;
    hi = lo + ($urandom >> $urandom_range(0, 31));
    if (hi < lo) hi = 32'hFFFF_FFFF;
    if ($urandom_range(7) == 0) begin
      lo = 0;
      hi = 32'hFFFF_FFFF;
    end
    load_band(3'($urandom), lo, hi,
              ($urandom_range(7) == 0) ? 32'd0 : ($urandom >> $urandom_range(0, 31)),
              8'($urandom), 8'($urandom),
              ($urandom_range(3) == 0) ? aux_skip : 8'($urandom));
  endtask

  task automatic test_random(input int idle_pct, input int items);
    int sent, k, count;
    logic [63:0] span;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < items) begin
      k = $urandom_range(9);
      if (k == 0) begin
        random_band();
        sent++;
      end else if (k == 1) begin
        scramble_fields();
        send_command(3'($urandom));
        sent++;
      end else begin
        count = (bands_used > 8) ? 8 : bands_used;
        k = (count == 0) ? 0 : $urandom_range(count - 1);
        span = {32'd0, high_tab[k]} - {32'd0, low_tab[k]} + 1;
        tune((count == 0 || $urandom_range(9) == 0) ? 32'($urandom)
             : 32'({32'd0, low_tab[k]} + ({$urandom, $urandom} % span)));
        scramble_fields();
        send_command(OpStart);
        sent += 2;
        repeat ($urandom_range(0, 12)) begin
          if ($urandom_range(15) == 0) begin
            scramble_fields();
            send_command(OpStart);
          end else begin
            poll($urandom_range(7) == 0);
          end
          sent++;
        end
        if ($urandom_range(1)) begin
          scramble_fields();
          send_command(OpStop);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    pll_result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: kind %0d byte %02h code %0d",
               kind, bus_byte, status_code);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatch_count++;
        end
        if (bus_byte !== want.bus_byte) begin
          $error("bus_byte: expected %02h, got %02h", want.bus_byte, bus_byte);
          mismatch_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
          mismatch_count++;
        end
        if (status_code !== want.status_code) begin
          $error("status_code: expected %0d, got %0d", want.status_code, status_code);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    if_hz = '0;
    bands_used = '0;
    lock_limit_ms = LockTimeoutReset;
    aux_skip = '0;
    mode = ModeUnconf;
    lock_wait = 1'b0;
    elapsed = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_idle_commands();
    test_band_table();
    test_lock_sequence();
    write_register(CfgIf, 32'd0);
    write_register(CfgBands, 32'd8);
    write_register(CfgTimeout, 32'd300);
    write_register(CfgAuxSkip, 32'd0);
    test_random(21, 140);
    write_register(CfgIf, $urandom);
    write_register(CfgTimeout, 32'd1000);
    write_register(CfgAuxSkip, $urandom);
    test_random(57, 140);
    write_register(CfgIf, 32'hFFFF_FFFF);
    write_register(CfgBands, 32'd5);
    write_register(CfgTimeout, 32'd100);
    test_random(0, 140);
    drain();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d expected results never arrived", expected_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $error("run timed out with %0d results outstanding", expected_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ptp_pkg.sv
rtl/ptp_datapath.sv
rtl/ptp_controller.sv
rtl/pll_tuner_programmer_top.sv
tb/sv/pll_tuner_programmer_top_tb.sv
